FILE: hdl/drsl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drsl_pkg: shared types and constants of the dual-rate slew limiter
// Field widths, Q2.14 limits, register indexes and the bundles between the
// top level, the axis lanes and the output merge stage.
// ----------------------------------------------------------------------------
package drsl_pkg;

  localparam int unsigned NUM_CONTROLS = 9;
  localparam int unsigned AXIS_W       = 15;
  localparam int unsigned LEVEL_W      = 16;
  localparam int unsigned CURVE_W      = 33;
  localparam int unsigned DECAY_W      = 17;
  localparam int unsigned STEP_W       = 16;
  localparam int unsigned CAM_W        = 3;
  localparam int unsigned CFG_IDX_W    = 3;

  // Q2.14 limits
  localparam logic [AXIS_W-1:0]         AXIS_ONE   = 15'd16384;
  localparam logic signed [LEVEL_W-1:0] LEVEL_ONE  = 16'sd16384;
  localparam logic signed [LEVEL_W-1:0] LEVEL_MONE = -16'sd16384;
  localparam logic [DECAY_W-1:0]        DECAY_UNIT = 17'h10000;

  localparam logic [CURVE_W-1:0] CURVE_RESET = 33'h1_0000_0100;
  localparam logic [AXIS_W-1:0]  ASTEP_RESET = 15'd256;

  // digital mask bit positions
  localparam int unsigned BIT_FWD   = 0;
  localparam int unsigned BIT_REV   = 1;
  localparam int unsigned BIT_RIGHT = 2;
  localparam int unsigned BIT_LEFT  = 3;
  localparam int unsigned BIT_DRIFT = 4;
  localparam int unsigned BIT_CAM0  = 5;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DIG_THR_CURVE  = 3'd0,
    REG_DIG_THR_CENTER = 3'd1,
    REG_ANA_THR_STEP   = 3'd2,
    REG_DIG_STR_CURVE  = 3'd3,
    REG_DIG_STR_CENTER = 3'd4,
    REG_ANA_STR_STEP   = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    logic [CURVE_W-1:0] curve;
    logic [CURVE_W-1:0] center;
    logic [AXIS_W-1:0]  astep;
  } lane_cfg_t;

  typedef struct packed {
    logic              plus;
    logic              minus;
    logic [AXIS_W-1:0] a_plus;
    logic [AXIS_W-1:0] a_minus;
    logic              rev;
  } lane_req_t;

  typedef struct packed {
    logic                      done;
    logic signed [LEVEL_W-1:0] level;
  } lane_sts_t;

  typedef struct packed {
    logic             drift_brake;
    logic [CAM_W-1:0] cam_sel;
  } side_t;

endpackage

FILE: hdl/drsl_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drsl_in_if / drsl_out_if: valid-ready channels of the slew limiter
// One control tick in, one throttle/steering result out.
// ----------------------------------------------------------------------------
interface drsl_in_if;
  logic                                valid;
  logic                                ready;
  logic [drsl_pkg::NUM_CONTROLS-1:0]   digital_mask;
  logic [drsl_pkg::AXIS_W-1:0]         axis_fwd;
  logic [drsl_pkg::AXIS_W-1:0]         axis_rev;
  logic [drsl_pkg::AXIS_W-1:0]         axis_right;
  logic [drsl_pkg::AXIS_W-1:0]         axis_left;
  logic [drsl_pkg::AXIS_W-1:0]         axis_drift;
  logic [drsl_pkg::AXIS_W-1:0]         axis_cam_a;
  logic [drsl_pkg::AXIS_W-1:0]         axis_cam_b;
  logic [drsl_pkg::AXIS_W-1:0]         axis_cam_c;
  logic [drsl_pkg::AXIS_W-1:0]         axis_cam_d;
  logic                                reversed;

  modport source (
    output valid, digital_mask, axis_fwd, axis_rev, axis_right, axis_left,
           axis_drift, axis_cam_a, axis_cam_b, axis_cam_c, axis_cam_d, reversed,
    input  ready
  );
  modport sink (
    input  valid, digital_mask, axis_fwd, axis_rev, axis_right, axis_left,
           axis_drift, axis_cam_a, axis_cam_b, axis_cam_c, axis_cam_d, reversed,
    output ready
  );
endinterface

interface drsl_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [drsl_pkg::LEVEL_W-1:0] throttle_out;
  logic signed [drsl_pkg::LEVEL_W-1:0] steer_out;
  logic                                drift_brake;
  logic [drsl_pkg::CAM_W-1:0]          cam_sel;

  modport source (
    output valid, throttle_out, steer_out, drift_brake, cam_sel,
    input  ready
  );
  modport sink (
    input  valid, throttle_out, steer_out, drift_brake, cam_sel,
    output ready
  );
endinterface

FILE: hdl/dual_rate_slew_limiter_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dual_rate_slew_limiter_top: throttle and steering slew limiter
// Each control tick moves the Q2.14 throttle and steering levels toward the
// requested value along programmable decay-and-step curves.
// ----------------------------------------------------------------------------
// A tick is taken on the input channel only while no earlier tick is still in
// the lanes; throttle and steering are handled by two identical lanes that
// run at the same time. Each lane does a curve pass as a multiply step (a
// 16x17 multiply into a register) and an adjust step (step subtract and
// saturation); when a digital request points past zero and the center curve
// reaches or crosses zero, a normal-curve pass follows. The merge stage loads
// the output register once both lanes are done, unless the output side stalls,
// and the next tick can be taken in the cycle after. A finished result waits
// in the output register while the next tick is already accepted.
// Configuration writes must only be issued while no tick is in flight.
// ----------------------------------------------------------------------------
module dual_rate_slew_limiter_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [drsl_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [drsl_pkg::CURVE_W-1:0]      cfg_wdata_i,
  drsl_in_if.sink                           in_chan,
  drsl_out_if.source                        out_chan
);

  // configuration registers
  logic [drsl_pkg::CURVE_W-1:0] thr_curve_q, thr_center_q, str_curve_q, str_center_q;
  logic [drsl_pkg::AXIS_W-1:0]  thr_astep_q, str_astep_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_curve_q  <= drsl_pkg::CURVE_RESET;
      thr_center_q <= drsl_pkg::CURVE_RESET;
      thr_astep_q  <= drsl_pkg::ASTEP_RESET;
      str_curve_q  <= drsl_pkg::CURVE_RESET;
      str_center_q <= drsl_pkg::CURVE_RESET;
      str_astep_q  <= drsl_pkg::ASTEP_RESET;
    end else if (cfg_we_i) begin
      unique case (drsl_pkg::cfg_reg_e'(cfg_idx_i))
        drsl_pkg::REG_DIG_THR_CURVE:  thr_curve_q  <= cfg_wdata_i;
        drsl_pkg::REG_DIG_THR_CENTER: thr_center_q <= cfg_wdata_i;
        drsl_pkg::REG_ANA_THR_STEP:   thr_astep_q  <= cfg_wdata_i[drsl_pkg::AXIS_W-1:0];
        drsl_pkg::REG_DIG_STR_CURVE:  str_curve_q  <= cfg_wdata_i;
        drsl_pkg::REG_DIG_STR_CENTER: str_center_q <= cfg_wdata_i;
        drsl_pkg::REG_ANA_STR_STEP:   str_astep_q  <= cfg_wdata_i[drsl_pkg::AXIS_W-1:0];
        default: ; // unknown index, write dropped
      endcase
    end
  end

  drsl_pkg::lane_cfg_t thr_cfg, str_cfg;
  assign thr_cfg = '{curve: thr_curve_q, center: thr_center_q, astep: thr_astep_q};
  assign str_cfg = '{curve: str_curve_q, center: str_center_q, astep: str_astep_q};

  // input transfer
  logic busy;
  logic accept;
  logic take;

  assign in_chan.ready = !busy;
  assign accept        = in_chan.valid && !busy;

  // per-lane requests; forward/right are the plus direction
  drsl_pkg::lane_req_t thr_req, str_req;
  assign thr_req = '{plus:    in_chan.digital_mask[drsl_pkg::BIT_FWD],
                     minus:   in_chan.digital_mask[drsl_pkg::BIT_REV],
                     a_plus:  in_chan.axis_fwd,
                     a_minus: in_chan.axis_rev,
                     rev:     in_chan.reversed};
  assign str_req = '{plus:    in_chan.digital_mask[drsl_pkg::BIT_RIGHT],
                     minus:   in_chan.digital_mask[drsl_pkg::BIT_LEFT],
                     a_plus:  in_chan.axis_right,
                     a_minus: in_chan.axis_left,
                     rev:     in_chan.reversed};

  // drift brake and camera priority, captured with the tick
  logic [3:0]      cam_hit;
  drsl_pkg::side_t side;

  always_comb begin
    cam_hit[0] = in_chan.digital_mask[drsl_pkg::BIT_CAM0]     || (in_chan.axis_cam_a != '0);
    cam_hit[1] = in_chan.digital_mask[drsl_pkg::BIT_CAM0 + 1] || (in_chan.axis_cam_b != '0);
    cam_hit[2] = in_chan.digital_mask[drsl_pkg::BIT_CAM0 + 2] || (in_chan.axis_cam_c != '0);
    cam_hit[3] = in_chan.digital_mask[drsl_pkg::BIT_CAM0 + 3] || (in_chan.axis_cam_d != '0);
    side.drift_brake = in_chan.digital_mask[drsl_pkg::BIT_DRIFT]
                     || (in_chan.axis_drift != '0);
    // lowest numbered camera wins
    side.cam_sel = '0;
    for (int i = 3; i >= 0; i--) begin
      if (cam_hit[i]) begin
        side.cam_sel = drsl_pkg::CAM_W'(i + 1);
      end
    end
  end

  drsl_pkg::lane_sts_t thr_sts, str_sts;

  // throttle lane
  drsl_lane u_thr_lane (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (accept),
    .take_i  (take),
    .req_i   (thr_req),
    .cfg_i   (thr_cfg),
    .sts_o   (thr_sts)
  );

  // steering lane
  drsl_lane u_str_lane (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (accept),
    .take_i  (take),
    .req_i   (str_req),
    .cfg_i   (str_cfg),
    .sts_o   (str_sts)
  );

  // join both lanes into one result and hold it for the output transfer
  drsl_merge u_merge (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .side_i    (side),
    .thr_sts_i (thr_sts),
    .str_sts_i (str_sts),
    .take_o    (take),
    .busy_o    (busy),
    .out_chan  (out_chan)
  );

endmodule

FILE: hdl/drsl_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drsl_lane: one axis of the slew limiter
// Holds the axis level and moves it toward the wanted value with a
// multiply pass followed by an adjust pass, twice when crossing zero.
// ----------------------------------------------------------------------------
module drsl_lane (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic                  take_i,
  input  drsl_pkg::lane_req_t   req_i,
  input  drsl_pkg::lane_cfg_t   cfg_i,
  output drsl_pkg::lane_sts_t   sts_o
);

  typedef enum logic [3:0] {
    L_IDLE = 4'b0001,
    L_MUL  = 4'b0010,
    L_ADJ  = 4'b0100,
    L_DONE = 4'b1000
  } lane_state_e;

  localparam int unsigned LW = drsl_pkg::LEVEL_W;
  localparam int unsigned SW = 20;

  function automatic logic [drsl_pkg::AXIS_W-1:0] sat_axis(
    input logic [drsl_pkg::AXIS_W-1:0] v);
    return (v > drsl_pkg::AXIS_ONE) ? drsl_pkg::AXIS_ONE : v;
  endfunction

  function automatic logic opposite(input logic signed [LW-1:0] a,
                                    input logic signed [LW-1:0] b);
    return ((a < 0) && (b > 0)) || ((a > 0) && (b < 0));
  endfunction

  lane_state_e state_q, state_d;

  logic signed [LW-1:0]                level_q;
  logic                                was_analog_q;
  logic                                cross_q;
  logic signed [LW-1:0]                op_level_q;
  logic signed [LW-1:0]                wanted_q;
  logic [drsl_pkg::DECAY_W-1:0]        decay_q;
  logic [drsl_pkg::STEP_W-1:0]         step_q;
  logic                                pos_q;
  logic [drsl_pkg::CURVE_W-1:0]        product_q;

  // setup of the first pass
  logic                                dig, ana;
  logic signed [LW-1:0]                want_dig, want_ana, set_wanted;
  logic signed [LW:0]                  ana_diff;
  logic [drsl_pkg::CURVE_W-1:0]        set_word;
  logic                                set_unit, set_cross, set_was;
  logic [drsl_pkg::DECAY_W-1:0]        set_decay;
  logic [drsl_pkg::STEP_W-1:0]         set_step;

  always_comb begin
    dig      = req_i.plus ^ req_i.minus;
    ana      = (req_i.a_plus != '0) || (req_i.a_minus != '0);
    want_dig = (req_i.plus ^ req_i.rev) ? drsl_pkg::LEVEL_ONE : drsl_pkg::LEVEL_MONE;
    ana_diff = $signed({2'b00, sat_axis(req_i.a_plus)})
             - $signed({2'b00, sat_axis(req_i.a_minus)});
    if (req_i.rev) begin
      ana_diff = -ana_diff;
    end
    want_ana = ana_diff[LW-1:0];

    set_cross = 1'b0;
    set_unit  = 1'b0;
    set_was   = was_analog_q;
    set_word  = cfg_i.center;
    if (dig) begin
      set_wanted = want_dig;
      set_was    = 1'b0;
      set_cross  = opposite(level_q, want_dig);
      set_word   = set_cross ? cfg_i.center : cfg_i.curve;
    end else if (ana) begin
      set_wanted = want_ana;
      set_was    = 1'b1;
      set_unit   = 1'b1;
    end else begin
      set_wanted = '0;
      set_unit   = was_analog_q;
    end

    if (set_unit) begin
      set_decay = drsl_pkg::DECAY_UNIT;
      set_step  = {1'b0, cfg_i.astep};
    end else begin
      set_decay = set_word[drsl_pkg::CURVE_W-1:drsl_pkg::STEP_W];
      set_step  = set_word[drsl_pkg::STEP_W-1:0];
    end
  end

  // multiply pass: |level - wanted| * decay
  logic signed [LW:0]           delta;
  logic                         dist_pos;
  logic [LW:0]                  dist_abs;
  logic [drsl_pkg::CURVE_W-1:0] product_d;

  always_comb begin
    delta     = {op_level_q[LW-1], op_level_q} - {wanted_q[LW-1], wanted_q};
    dist_pos  = (delta > 0);
    dist_abs  = dist_pos ? delta : -delta;
    product_d = drsl_pkg::CURVE_W'(dist_abs[LW-1:0]) * drsl_pkg::CURVE_W'(decay_q);
  end

  // adjust pass: subtract the step, no overshoot, saturate
  logic [drsl_pkg::DECAY_W-1:0] scaled, rem;
  logic                         over;
  logic signed [SW-1:0]         wanted_w, rem_w, sum_w;
  logic signed [LW-1:0]         res;
  logic                         second;

  always_comb begin
    scaled   = product_q[drsl_pkg::CURVE_W-1:drsl_pkg::STEP_W];
    over     = scaled > {1'b0, step_q};
    rem      = scaled - {1'b0, step_q};
    wanted_w = SW'(wanted_q);
    rem_w    = $signed(SW'(rem));
    sum_w    = pos_q ? (wanted_w + rem_w) : (wanted_w - rem_w);
    if (!over) begin
      res = wanted_q;
    end else if (sum_w > SW'(drsl_pkg::LEVEL_ONE)) begin
      res = drsl_pkg::LEVEL_ONE;
    end else if (sum_w < SW'(drsl_pkg::LEVEL_MONE)) begin
      res = drsl_pkg::LEVEL_MONE;
    end else begin
      res = sum_w[LW-1:0];
    end
    // crossed or reached zero on the center curve: go on with the normal curve
    second = cross_q && !opposite(res, wanted_q);
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      L_IDLE: if (start_i) state_d = L_MUL;
      L_MUL:  state_d = L_ADJ;
      L_ADJ:  state_d = second ? L_MUL : L_DONE;
      L_DONE: if (take_i) state_d = L_IDLE;
      default: state_d = L_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= L_IDLE;
      level_q      <= '0;
      was_analog_q <= 1'b0;
      cross_q      <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == L_IDLE && start_i) begin
        was_analog_q <= set_was;
        cross_q      <= set_cross;
      end
      if (state_q == L_ADJ) begin
        if (second) begin
          cross_q <= 1'b0;
        end else begin
          level_q <= res;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == L_IDLE && start_i) begin
      op_level_q <= level_q;
      wanted_q   <= set_wanted;
      decay_q    <= set_decay;
      step_q     <= set_step;
    end
    if (state_q == L_MUL) begin
      product_q <= product_d;
      pos_q     <= dist_pos;
    end
    if (state_q == L_ADJ && second) begin
      op_level_q <= '0;
      decay_q    <= cfg_i.curve[drsl_pkg::CURVE_W-1:drsl_pkg::STEP_W];
      step_q     <= cfg_i.curve[drsl_pkg::STEP_W-1:0];
    end
  end

  assign sts_o.done  = (state_q == L_DONE);
  assign sts_o.level = level_q;

endmodule

FILE: hdl/drsl_merge.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drsl_merge: result merge and output register
// Waits for both lanes, joins their levels with the drift and camera flags
// and holds the result until the output transfer.
// ----------------------------------------------------------------------------
module drsl_merge (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 accept_i,
  input  drsl_pkg::side_t      side_i,
  input  drsl_pkg::lane_sts_t  thr_sts_i,
  input  drsl_pkg::lane_sts_t  str_sts_i,
  output logic                 take_o,
  output logic                 busy_o,
  drsl_out_if.source           out_chan
);

  logic            busy_q;
  logic            out_valid_q;
  drsl_pkg::side_t side_q;

  assign take_o = busy_q && thr_sts_i.done && str_sts_i.done
                && (!out_valid_q || out_chan.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept_i) begin
        busy_q <= 1'b1;
      end else if (take_o) begin
        busy_q <= 1'b0;
      end
      if (take_o) begin
        out_valid_q <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      side_q <= side_i;
    end
    if (take_o) begin
      out_chan.throttle_out <= thr_sts_i.level;
      out_chan.steer_out    <= str_sts_i.level;
      out_chan.drift_brake  <= side_q.drift_brake;
      out_chan.cam_sel      <= side_q.cam_sel;
    end
  end

  assign out_chan.valid = out_valid_q;
  assign busy_o         = busy_q;

endmodule

FILE: tb/sv/tb_dual_rate_slew_limiter_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_dual_rate_slew_limiter_top: self-checking bench of the slew limiter
// Drives control ticks through the valid-ready input channel and compares
// every result with a cycle-free predictor of the throttle and steering
// lanes. Runs reset defaults, a directed set, and fixed and random register settings.
// ----------------------------------------------------------------------------
module tb_dual_rate_slew_limiter_top;
  import drsl_pkg::*;

  // timing and run shape
  localparam int SETTLE_CYCLES  = 8;
  localparam int WATCHDOG_LIMIT = 2000;  // cycles without any transfer or write
  localparam int RESET_TICKS    = 30;
  localparam int PHASE_TICKS    = 240;
  localparam int NUM_PHASES     = 8;
  localparam int CALM_PHASE     = 3;     // no idling on either side here
  localparam int IDLE_PCT       = 34;

  localparam int    FULL_SCALE = int'(LEVEL_ONE);
  localparam longint UNIT_GAIN = 65536;

  // register indexes that decode to nothing
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;

  typedef enum int {REQ_NONE, REQ_PLUS, REQ_MINUS, REQ_BOTH, REQ_ANALOG} req_mode_e;

  typedef struct packed {
    logic [NUM_CONTROLS-1:0] mask;
    logic [AXIS_W-1:0]       axis_fwd;
    logic [AXIS_W-1:0]       axis_rev;
    logic [AXIS_W-1:0]       axis_right;
    logic [AXIS_W-1:0]       axis_left;
    logic [AXIS_W-1:0]       axis_drift;
    logic [AXIS_W-1:0]       axis_cam_a;
    logic [AXIS_W-1:0]       axis_cam_b;
    logic [AXIS_W-1:0]       axis_cam_c;
    logic [AXIS_W-1:0]       axis_cam_d;
    logic                    reversed;
  } tick_t;

  typedef struct packed {
    logic signed [LEVEL_W-1:0] throttle;
    logic signed [LEVEL_W-1:0] steer;
    logic                      drift_brake;
    logic [CAM_W-1:0]          cam_sel;
  } result_t;

  // predictor of both lanes plus the queue of results still owed by the block
  class slew_scoreboard;
    logic [CURVE_W-1:0] thr_curve, thr_center, str_curve, str_center;
    logic [AXIS_W-1:0]  thr_astep, str_astep;
    int                 thr_level, str_level;
    bit                 thr_analog, str_analog;
    result_t            owed[$];
    int                 n_errors;
    int                 n_checked;

    function new();
      thr_curve  = CURVE_RESET;
      thr_center = CURVE_RESET;
      str_curve  = CURVE_RESET;
      str_center = CURVE_RESET;
      thr_astep  = ASTEP_RESET;
      str_astep  = ASTEP_RESET;
      thr_level  = 0;
      str_level  = 0;
      thr_analog = 1'b0;
      str_analog = 1'b0;
      n_errors   = 0;
      n_checked  = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CURVE_W-1:0] data);
      case (idx)
        REG_DIG_THR_CURVE:  thr_curve  = data;
        REG_DIG_THR_CENTER: thr_center = data;
        REG_ANA_THR_STEP:   thr_astep  = data[AXIS_W-1:0];
        REG_DIG_STR_CURVE:  str_curve  = data;
        REG_DIG_STR_CENTER: str_center = data;
        REG_ANA_STR_STEP:   str_astep  = data[AXIS_W-1:0];
        default: ;
      endcase
    endfunction

    function int clamp_level(longint v);
      if (v > FULL_SCALE) return FULL_SCALE;
      if (v < -FULL_SCALE) return -FULL_SCALE;
      return int'(v);
    endfunction

    function int clip_axis(logic [AXIS_W-1:0] a);
      return (a > AXIS_ONE) ? FULL_SCALE : int'(a);
    endfunction

    // scale the remaining distance, take off the step, never overshoot
    function int curve_tick(int level, int wanted, longint gain, longint step_sz);
      longint dist_v, mag, scaled, rem;
      bit     above;
      dist_v = longint'(level) - longint'(wanted);
      above  = dist_v > 0;
      mag    = above ? dist_v : -dist_v;
      scaled = (mag * gain) >> 16;
      if (scaled > step_sz) begin
        rem = scaled - step_sz;
        return clamp_level(above ? wanted + rem : wanted - rem);
      end
      return wanted;
    endfunction

    function int word_tick(int level, int wanted, logic [CURVE_W-1:0] word);
      longint gain, step_sz;
      gain    = longint'(word[CURVE_W-1:STEP_W]);
      step_sz = longint'(word[STEP_W-1:0]);
      return curve_tick(level, wanted, gain, step_sz);
    endfunction

    function bit sides_differ(int a, int b);
      return (a < 0 && b > 0) || (a > 0 && b < 0);
    endfunction

    // center curve first when the request points past zero
    function int digital_tick(int level, int wanted, logic [CURVE_W-1:0] curve,
                              logic [CURVE_W-1:0] center);
      int lvl;
      lvl = level;
      if (sides_differ(lvl, wanted)) begin
        lvl = word_tick(lvl, wanted, center);
        if (sides_differ(lvl, wanted)) return lvl;
        lvl = 0;
      end
      return word_tick(lvl, wanted, curve);
    endfunction

    function int lane_tick(input int level, inout bit was_analog, input bit plus,
                           input bit minus, input logic [AXIS_W-1:0] a_plus,
                           input logic [AXIS_W-1:0] a_minus, input bit rev,
                           input logic [CURVE_W-1:0] curve,
                           input logic [CURVE_W-1:0] center,
                           input logic [AXIS_W-1:0] astep);
      int sgn;
      int wanted;
      sgn = rev ? -1 : 1;
      if (plus && !minus) begin
        was_analog = 1'b0;
        return digital_tick(level, FULL_SCALE * sgn, curve, center);
      end
      if (!plus && minus) begin
        was_analog = 1'b0;
        return digital_tick(level, -FULL_SCALE * sgn, curve, center);
      end
      if (a_plus != '0 || a_minus != '0) begin
        wanted     = (clip_axis(a_plus) - clip_axis(a_minus)) * sgn;
        was_analog = 1'b1;
        return curve_tick(level, wanted, UNIT_GAIN, longint'(astep));
      end
      if (was_analog) return curve_tick(level, 0, UNIT_GAIN, longint'(astep));
      return word_tick(level, 0, center);
    endfunction

    function void note_tick(tick_t t);
      result_t r;
      logic [3:0] cam_req;
      cam_req[0] = t.mask[BIT_CAM0]   || t.axis_cam_a != '0;
      cam_req[1] = t.mask[BIT_CAM0+1] || t.axis_cam_b != '0;
      cam_req[2] = t.mask[BIT_CAM0+2] || t.axis_cam_c != '0;
      cam_req[3] = t.mask[BIT_CAM0+3] || t.axis_cam_d != '0;
      thr_level = lane_tick(thr_level, thr_analog, t.mask[BIT_FWD], t.mask[BIT_REV],
                            t.axis_fwd, t.axis_rev, t.reversed, thr_curve, thr_center,
                            thr_astep);
      str_level = lane_tick(str_level, str_analog, t.mask[BIT_RIGHT], t.mask[BIT_LEFT],
                            t.axis_right, t.axis_left, t.reversed, str_curve, str_center,
                            str_astep);
      r.throttle    = thr_level[LEVEL_W-1:0];
      r.steer       = str_level[LEVEL_W-1:0];
      r.drift_brake = t.mask[BIT_DRIFT] || t.axis_drift != '0;
      if (cam_req[0])      r.cam_sel = 3'd1;
      else if (cam_req[1]) r.cam_sel = 3'd2;
      else if (cam_req[2]) r.cam_sel = 3'd3;
      else if (cam_req[3]) r.cam_sel = 3'd4;
      else                 r.cam_sel = 3'd0;
      owed.push_back(r);
    endfunction

    task report(string msg);
      $display("%0t ns mismatch: %s", $time, msg);
      n_errors++;
    endtask

    task check_result(result_t got);
      result_t want;
      if (owed.size() == 0) begin
        report($sformatf("result with nothing owed: throttle %0d steer %0d",
                         got.throttle, got.steer));
        return;
      end
      want = owed.pop_front();
      n_checked++;
      if (got.throttle !== want.throttle)
        report($sformatf("throttle got %0d want %0d", got.throttle, want.throttle));
      if (got.steer !== want.steer)
        report($sformatf("steer got %0d want %0d", got.steer, want.steer));
      if (got.drift_brake !== want.drift_brake)
        report($sformatf("drift_brake got %b want %b", got.drift_brake, want.drift_brake));
      if (got.cam_sel !== want.cam_sel)
        report($sformatf("cam_sel got %0d want %0d", got.cam_sel, want.cam_sel));
    endtask
  endclass

  // --------------------------------------------------------------------------
  // clock, reset, channels and the block
  // --------------------------------------------------------------------------
  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CURVE_W-1:0]   cfg_wdata_i;

  drsl_in_if  in_if ();
  drsl_out_if out_if ();

  dual_rate_slew_limiter_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_chan     (in_if),
    .out_chan    (out_if)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  slew_scoreboard sb;
  bit calm;          // both sides run without idling
  int n_ticks;       // accepted ticks
  int n_settings;    // register settings programmed
  int idle_cycles;   // cycles since the last transfer or write

  // --------------------------------------------------------------------------
  // monitor: ticks and results are taken from the pre-edge values
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_if.valid && in_if.ready) begin
        sb.note_tick('{in_if.digital_mask, in_if.axis_fwd, in_if.axis_rev,
                       in_if.axis_right, in_if.axis_left, in_if.axis_drift,
                       in_if.axis_cam_a, in_if.axis_cam_b, in_if.axis_cam_c,
                       in_if.axis_cam_d, in_if.reversed});
        n_ticks++;
      end
      if (out_if.valid && out_if.ready)
        sb.check_result('{out_if.throttle_out, out_if.steer_out,
                          out_if.drift_brake, out_if.cam_sel});
    end
  end

  // output side stalls at random, except in the calm phase
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // watchdog: a run that stops moving is a failure
  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) || cfg_we_i) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t ns watchdog: no transfer for %0d cycles, %0d results owed",
                 $time, idle_cycles, sb.owed.size());
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // register writes: the enable is high for one cycle, then driven low
  // --------------------------------------------------------------------------
  task write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CURVE_W-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    sb.write_reg(idx, data);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task program_regs(input logic [CURVE_W-1:0] thr_c, input logic [CURVE_W-1:0] thr_ctr,
                    input logic [CURVE_W-1:0] thr_a, input logic [CURVE_W-1:0] str_c,
                    input logic [CURVE_W-1:0] str_ctr, input logic [CURVE_W-1:0] str_a);
    write_reg(REG_DIG_THR_CURVE, thr_c);
    write_reg(REG_DIG_THR_CENTER, thr_ctr);
    write_reg(REG_ANA_THR_STEP, thr_a);
    write_reg(REG_DIG_STR_CURVE, str_c);
    write_reg(REG_DIG_STR_CENTER, str_ctr);
    write_reg(REG_ANA_STR_STEP, str_a);
    n_settings++;
  endtask

  // decay mostly at or just under unity so the levels travel the whole range
  function automatic logic [CURVE_W-1:0] random_curve();
    logic [DECAY_W-1:0] gain;
    logic [STEP_W-1:0]  step_sz;
    int r;
    r = $urandom_range(0, 99);
    if (r < 30)      gain = 17'($urandom_range(32'h8000, 32'h10000));
    else if (r < 50) gain = DECAY_UNIT;
    else if (r < 70) gain = 17'($urandom_range(0, 32'h1FFFF));
    else             gain = 17'($urandom_range(32'hC000, 32'hFFFF));
    if ($urandom_range(0, 99) < 70) step_sz = 16'($urandom_range(0, 2048));
    else                            step_sz = 16'($urandom);
    return {gain, step_sz};
  endfunction

  // upper write bits are junk now and then; the step keeps its low 15 bits
  function automatic logic [CURVE_W-1:0] random_astep();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return CURVE_W'($urandom_range(1, 4096));
    if (r < 85) return CURVE_W'($urandom_range(0, 16384));
    return {1'($urandom), 32'($urandom)};
  endfunction

  // --------------------------------------------------------------------------
  // input side
  // --------------------------------------------------------------------------
  task send_tick(input tick_t t);
    int gap;
    gap = 0;
    if (!calm)
      while (gap < 40 && $urandom_range(0, 99) < IDLE_PCT) gap++;
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid        <= 1'b1;
    in_if.digital_mask <= t.mask;
    in_if.axis_fwd     <= t.axis_fwd;
    in_if.axis_rev     <= t.axis_rev;
    in_if.axis_right   <= t.axis_right;
    in_if.axis_left    <= t.axis_left;
    in_if.axis_drift   <= t.axis_drift;
    in_if.axis_cam_a   <= t.axis_cam_a;
    in_if.axis_cam_b   <= t.axis_cam_b;
    in_if.axis_cam_c   <= t.axis_cam_c;
    in_if.axis_cam_d   <= t.axis_cam_d;
    in_if.reversed     <= t.reversed;
    do @(posedge clk_i); while (!in_if.ready);
  endtask

  // called in the step of the last transfer, so valid drops before a re-take;
  // and the clock edge awaited first lets the monitor note that transfer
  task drain_results();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (sb.owed.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  function automatic tick_t tick_of(logic [NUM_CONTROLS-1:0] mask, logic [AXIS_W-1:0] fwd,
                                    logic [AXIS_W-1:0] rev, logic [AXIS_W-1:0] right,
                                    logic [AXIS_W-1:0] left, logic [AXIS_W-1:0] drift,
                                    logic [AXIS_W-1:0] cam_a, logic [AXIS_W-1:0] cam_b,
                                    logic [AXIS_W-1:0] cam_c, logic [AXIS_W-1:0] cam_d,
                                    logic reversed);
    return '{mask, fwd, rev, right, left, drift, cam_a, cam_b, cam_c, cam_d, reversed};
  endfunction

  function automatic logic [AXIS_W-1:0] pick_axis();
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) return '0;
    if (r < 25) return 15'($urandom_range(16385, 32767));  // saturates
    if (r < 35) return AXIS_ONE;
    return 15'($urandom_range(0, 16384));
  endfunction

  function automatic req_mode_e pick_mode();
    int r;
    r = $urandom_range(0, 99);
    if (r < 27) return REQ_PLUS;
    if (r < 54) return REQ_MINUS;
    if (r < 72) return REQ_ANALOG;
    if (r < 87) return REQ_NONE;
    return REQ_BOTH;
  endfunction

  // one lane's flags and axes for a given kind of request
  function automatic void fill_lane(input req_mode_e mode, output logic plus,
                                    output logic minus, output logic [AXIS_W-1:0] a_plus,
                                    output logic [AXIS_W-1:0] a_minus);
    plus    = (mode == REQ_PLUS) || (mode == REQ_BOTH);
    minus   = (mode == REQ_MINUS) || (mode == REQ_BOTH);
    a_plus  = '0;
    a_minus = '0;
    case (mode)
      REQ_PLUS, REQ_MINUS: begin
        // ignored under a digital request
        if ($urandom_range(0, 1) == 1) begin
          a_plus  = 15'($urandom);
          a_minus = 15'($urandom);
        end
      end
      REQ_BOTH: begin
        if ($urandom_range(0, 99) >= 40) begin
          a_plus  = pick_axis();
          a_minus = pick_axis();
        end
      end
      REQ_ANALOG: begin
        a_plus  = pick_axis();
        a_minus = pick_axis();
        if ($urandom_range(0, 99) < 30) begin
          if ($urandom_range(0, 1) == 1) a_plus = '0;
          else                           a_minus = '0;
        end
      end
      default: ;
    endcase
  endfunction

  function automatic tick_t random_tick(req_mode_e thr_mode, req_mode_e str_mode,
                                        bit rev);
    tick_t t;
    logic p, m;
    logic [AXIS_W-1:0] ap, am;
    t.mask = 9'($urandom);
    fill_lane(thr_mode, p, m, ap, am);
    t.mask[BIT_FWD] = p;
    t.mask[BIT_REV] = m;
    t.axis_fwd = ap;
    t.axis_rev = am;
    fill_lane(str_mode, p, m, ap, am);
    t.mask[BIT_RIGHT] = p;
    t.mask[BIT_LEFT]  = m;
    t.axis_right = ap;
    t.axis_left  = am;
    // sparse camera requests so the priority order gets exercised
    t.mask[BIT_CAM0 +: 4] = 4'($urandom & $urandom);
    t.axis_drift = ($urandom_range(0, 99) < 60) ? '0 : 15'($urandom);
    t.axis_cam_a = ($urandom_range(0, 99) < 75) ? '0 : 15'($urandom);
    t.axis_cam_b = ($urandom_range(0, 99) < 75) ? '0 : 15'($urandom);
    t.axis_cam_c = ($urandom_range(0, 99) < 75) ? '0 : 15'($urandom);
    t.axis_cam_d = ($urandom_range(0, 99) < 75) ? '0 : 15'($urandom);
    t.reversed   = rev ^ ($urandom_range(0, 99) < 5);
    return t;
  endfunction

  // runs of held requests with random content, some pure noise,
  // and one pause mid-way until every result is back
  task run_ticks(input int n);
    int sent, run_len;
    req_mode_e thr_mode, str_mode;
    bit rev;
    tick_t t;
    sent = 0;
    while (sent < n) begin
      thr_mode = pick_mode();
      str_mode = pick_mode();
      rev      = ($urandom_range(0, 99) < 25);
      run_len  = $urandom_range(1, 24);
      for (int k = 0; k < run_len && sent < n; k++) begin
        if ($urandom_range(0, 99) < 8)
          t = tick_of(9'($urandom), 15'($urandom), 15'($urandom), 15'($urandom),
                      15'($urandom), 15'($urandom), 15'($urandom), 15'($urandom),
                      15'($urandom), 15'($urandom), 1'($urandom));
        else
          t = random_tick(thr_mode, str_mode, rev);
        send_tick(t);
        sent++;
        if (sent == n / 2) drain_results();
      end
    end
  endtask

  // extremes of the fields, each request kind, zero crossings and cameras
  task directed_ticks();
    // idle, then full forward until the level sits at one
    send_tick(tick_of(9'h000, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1'b0));
    send_tick(tick_of(9'h001, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1'b0));
    send_tick(tick_of(9'h001, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1'b0));
    send_tick(tick_of(9'h001, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1'b0));
    // reverse past zero: center curve then normal curve
    send_tick(tick_of(9'h002, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1'b0));
    send_tick(tick_of(9'h002, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1'b0));
    // both directions held, no analog: centers the digital way
    send_tick(tick_of(9'h003, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1'b0));
    // both held with analog forward over full scale
    send_tick(tick_of(9'h003, 15'h7FFF, 0, 0, 0, 0, 0, 0, 0, 0, 1'b0));
    send_tick(tick_of(9'h000, 0, AXIS_ONE, 0, 0, 0, 0, 0, 0, 0, 1'b0));
    // no request after analog: linear centering
    send_tick(tick_of(9'h000, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1'b0));
    // steering right then left: slow center curve does not reach zero at once
    send_tick(tick_of(9'h004, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1'b0));
    send_tick(tick_of(9'h004, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1'b0));
    send_tick(tick_of(9'h008, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1'b0));
    send_tick(tick_of(9'h008, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1'b0));
    send_tick(tick_of(9'h00C, 0, 0, 0, 15'd5000, 0, 0, 0, 0, 0, 1'b0));
    // reversed direction on both lanes
    send_tick(tick_of(9'h005, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1'b1));
    send_tick(tick_of(9'h000, 15'd3000, 0, 15'd7000, 0, 0, 0, 0, 0, 0, 1'b1));
    // drift brake, digital and analog
    send_tick(tick_of(9'h010, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1'b0));
    send_tick(tick_of(9'h000, 0, 0, 0, 0, 15'd1, 0, 0, 0, 0, 1'b0));
    // camera priority, one source, two together and all at once
    send_tick(tick_of(9'h100, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1'b0));
    send_tick(tick_of(9'h0C0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1'b0));
    send_tick(tick_of(9'h000, 0, 0, 0, 0, 0, 0, 15'd100, 0, 15'd1, 1'b0));
    send_tick(tick_of(9'h000, 0, 0, 0, 0, 0, 0, 0, 0, 15'd1, 1'b0));
    send_tick(tick_of(9'h1E0, 0, 0, 0, 0, 0, AXIS_ONE, AXIS_ONE, AXIS_ONE, AXIS_ONE, 1'b0));
    // every field at its maximum
    send_tick(tick_of(9'h1FF, 15'h7FFF, 15'h7FFF, 15'h7FFF, 15'h7FFF, 15'h7FFF,
                      15'h7FFF, 15'h7FFF, 15'h7FFF, 15'h7FFF, 1'b1));
  endtask

  // --------------------------------------------------------------------------
  // test sequence
  // --------------------------------------------------------------------------
  initial begin
    sb          = new();
    calm        = 1'b0;
    n_ticks     = 0;
    n_settings  = 0;
    idle_cycles = 0;
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = '0;
    cfg_wdata_i = '0;
    in_if.valid        = 1'b0;
    in_if.digital_mask = '0;
    in_if.axis_fwd     = '0;
    in_if.axis_rev     = '0;
    in_if.axis_right   = '0;
    in_if.axis_left    = '0;
    in_if.axis_drift   = '0;
    in_if.axis_cam_a   = '0;
    in_if.axis_cam_b   = '0;
    in_if.axis_cam_c   = '0;
    in_if.axis_cam_d   = '0;
    in_if.reversed     = 1'b0;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset values of every register
    run_ticks(RESET_TICKS);
    drain_results();

    // fast throttle curves cross zero in one tick, slow steering center does not
    program_regs({17'h08000, 16'd4096}, {17'h08000, 16'd2048}, 33'd4096,
                 {17'h0C000, 16'd1024}, {17'h0E000, 16'd256}, 33'd8192);
    // writes to indexes that decode to nothing must leave the setting alone
    write_reg(REG_SPARE_A, 33'h1_FFFF_FFFF);
    write_reg(REG_SPARE_B, 33'h0_0000_0000);
    directed_ticks();
    drain_results();

    for (int p = 0; p < NUM_PHASES; p++) begin
      calm = (p == CALM_PHASE);
      case (p)
        // zero decay and step: curve moves land on the wanted value, analog steps stand still
        0: program_regs('0, '0, '0, '0, '0, '0);
        // curves at their top, analog step at full scale
        1: program_regs({CURVE_W{1'b1}}, {CURVE_W{1'b1}}, 33'd16384,
                        {CURVE_W{1'b1}}, {CURVE_W{1'b1}}, 33'd16384);
        // growing distance with no step: levels slam into saturation
        2: program_regs({17'h1FFFF, 16'd0}, {17'h1FFFF, 16'd0}, 33'd1,
                        {17'h1FFFF, 16'd0}, {17'h1FFFF, 16'd0}, 33'd1);
        default: begin
          program_regs(random_curve(), random_curve(), random_astep(),
                       random_curve(), random_curve(), random_astep());
          if ($urandom_range(0, 1) == 1)
            write_reg(($urandom_range(0, 1) == 1) ? REG_SPARE_A : REG_SPARE_B,
                      {1'($urandom), 32'($urandom)});
        end
      endcase
      run_ticks(PHASE_TICKS);
      drain_results();
    end
    calm = 1'b0;

    if (sb.owed.size() != 0)
      sb.report($sformatf("%0d results never arrived", sb.owed.size()));

    $display("summary: %0d control ticks over %0d register settings, %0d results compared",
             n_ticks, n_settings + 1, sb.n_checked);
    $display("summary: %0d mismatches", sb.n_errors);
    if (sb.n_errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
